// ===== rtl/core/dcwd_pkg.sv =====
// Shared types, codes and decode helpers for the DDS control word decoder.
package dcwd_pkg;

  // Field widths.
  localparam int HALF_W  = 14;
  localparam int PHASE_W = 12;
  localparam int FREQ_W  = 2 * HALF_W;

  // Transfers longer than this are dropped as too long.
  localparam logic [7:0] MAX_BYTES = 8'd4;

  // Action type in bits 15:14 of the first word.
  localparam logic [1:0] TYPE_CTRL  = 2'b00;
  localparam logic [1:0] TYPE_PHASE = 2'b11;

  // Bit positions inside the first word.
  localparam int BIT_FREQ_CHAN  = 15;
  localparam int BIT_PAIR       = 13;
  localparam int BIT_PHASE_CHAN = 13;
  localparam int BIT_UPPER      = 12;
  localparam int BIT_FSEL       = 11;
  localparam int BIT_PSEL       = 10;
  localparam int BIT_RESET      = 8;
  localparam int BIT_SLEEP_A    = 7;
  localparam int BIT_SLEEP_B    = 6;
  localparam int BIT_OPBITEN    = 5;
  localparam int BIT_DIV2       = 3;
  localparam int BIT_MODE       = 1;

  // Command codes produced by the classifier.
  localparam logic [2:0] OP_EMPTY      = 3'd0;
  localparam logic [2:0] OP_LONG       = 3'd1;
  localparam logic [2:0] OP_SHORT_PAIR = 3'd2;
  localparam logic [2:0] OP_PHASE      = 3'd3;
  localparam logic [2:0] OP_PAIR       = 3'd4;
  localparam logic [2:0] OP_UPPER      = 3'd5;
  localparam logic [2:0] OP_LOWER      = 3'd6;
  localparam logic [2:0] OP_CTRL       = 3'd7;

  // Reported event kinds.
  localparam logic [2:0] EV_EMPTY       = 3'd0;
  localparam logic [2:0] EV_LONG        = 3'd1;
  localparam logic [2:0] EV_SHORT_PAIR  = 3'd2;
  localparam logic [2:0] EV_PHASE       = 3'd3;
  localparam logic [2:0] EV_HALF        = 3'd4;
  localparam logic [2:0] EV_FREQ        = 3'd5;
  localparam logic [2:0] EV_ENTER_RESET = 3'd6;
  localparam logic [2:0] EV_CONTROL     = 3'd7;

  // Waveform codes.
  localparam logic [2:0] WAVE_NONE     = 3'd0;
  localparam logic [2:0] WAVE_OFF      = 3'd1;
  localparam logic [2:0] WAVE_SQ_HALF  = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd4;
  localparam logic [2:0] WAVE_SINE     = 3'd5;

  // Select value that means the select was never written.
  localparam logic [1:0] SEL_NEVER = 2'd2;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [2:0]        op;
    logic              chan;
    logic [HALF_W-1:0] data;
    logic [HALF_W-1:0] data2;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]         event_kind;
    logic               channel;
    logic [PHASE_W-1:0] phase_value;
    logic [FREQ_W-1:0]  frequency_word;
    logic               reset_active;
    logic [1:0]         freq_select_now;
    logic [1:0]         phase_select_now;
    logic [2:0]         waveform_now;
    logic               freq_select_changed;
    logic               phase_select_changed;
    logic               waveform_changed;
  } result_t;

  // Decode the waveform bits of a control word; some patterns keep the old code.
  function automatic logic [2:0] decode_wave(input logic [HALF_W-1:0] w,
                                             input logic [2:0] old);
    logic [2:0] res;
    res = old;
    if (w[BIT_SLEEP_A] || w[BIT_SLEEP_B]) begin
      res = WAVE_OFF;
    end else if (w[BIT_OPBITEN] && !w[BIT_MODE]) begin
      res = w[BIT_DIV2] ? WAVE_SQUARE : WAVE_SQ_HALF;
    end else if (!w[BIT_OPBITEN]) begin
      res = w[BIT_MODE] ? WAVE_TRIANGLE : WAVE_SINE;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/dcwd_if.sv =====
// Valid/ready channel interfaces for the transfer input and the event output.
interface dcwd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [7:0]  byte_count;

  modport source (output valid, first_word, second_word, byte_count, input ready);
  modport sink (input valid, first_word, second_word, byte_count, output ready);
endinterface

interface dcwd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic        channel;
  logic [11:0] phase_value;
  logic [27:0] frequency_word;
  logic        reset_active;
  logic [1:0]  freq_select_now;
  logic [1:0]  phase_select_now;
  logic [2:0]  waveform_now;
  logic        freq_select_changed;
  logic        phase_select_changed;
  logic        waveform_changed;

  modport source (output valid, event_kind, channel, phase_value, frequency_word,
                  reset_active, freq_select_now, phase_select_now, waveform_now,
                  freq_select_changed, phase_select_changed, waveform_changed,
                  input ready);
  modport sink (input valid, event_kind, channel, phase_value, frequency_word,
                reset_active, freq_select_now, phase_select_now, waveform_now,
                freq_select_changed, phase_select_changed, waveform_changed,
                output ready);
endinterface

// ===== rtl/core/dds_control_word_decoder_unit.sv =====
// Top level of the DDS control word decoder: classifier, command queue, executor.
//
//   Channel   Direction   Carries
//   in_ch     sink        first_word, second_word, byte_count (one serial transfer)
//   out_ch    source      one decoded event with the decoder state after it
//
// One transfer per clock is sustained while the output is not stalled; an accepted
// transfer is written into the queue, then executed into the output register.
// The state update and the result decode happen in the same cycle in the back end.
// rst_n is synchronous and active low; it empties the queue and output register
// and returns the selects to never set, the waveform to none, halves invalid.
// A stalled output holds its result; the two-entry queue keeps accepting until full.
module dds_control_word_decoder_unit
  import dcwd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  dcwd_in_if.sink       in_ch,
  dcwd_out_if.source    out_ch
);

  logic q_push;
  logic q_ready;
  cmd_t q_cmd_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd_out;

  dcwd_front u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (q_cmd_in)
  );

  dcwd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd_out)
  );

  dcwd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/core/dcwd_front.sv =====
// Front end: accepts transfers and classifies them into commands.
module dcwd_front
  import dcwd_pkg::*;
(
  dcwd_in_if.sink in_ch,
  input  logic    q_ready,
  output logic    q_push,
  output cmd_t    q_cmd
);

  // Accept whenever the command queue has room.
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // Classify the transfer by length and action type.
  always_comb begin
    q_cmd       = '0;
    q_cmd.data  = in_ch.first_word[HALF_W-1:0];
    q_cmd.data2 = in_ch.second_word[HALF_W-1:0];
    if (in_ch.byte_count == 8'd0) begin
      q_cmd.op = OP_EMPTY;
    end else if (in_ch.byte_count > MAX_BYTES) begin
      q_cmd.op = OP_LONG;
    end else begin
      case (in_ch.first_word[15:14])
        TYPE_PHASE: begin
          q_cmd.op   = OP_PHASE;
          q_cmd.chan = in_ch.first_word[BIT_PHASE_CHAN];
        end
        TYPE_CTRL: begin
          q_cmd.op = OP_CTRL;
        end
        default: begin
          q_cmd.chan = in_ch.first_word[BIT_FREQ_CHAN];
          if (in_ch.first_word[BIT_PAIR]) begin
            q_cmd.op = (in_ch.byte_count < MAX_BYTES) ? OP_SHORT_PAIR : OP_PAIR;
          end else begin
            q_cmd.op = in_ch.first_word[BIT_UPPER] ? OP_UPPER : OP_LOWER;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dcwd_queue.sv =====
// Two-entry command queue between the front end and the back end.
module dcwd_queue
  import dcwd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  localparam int DEPTH = 2;

  cmd_t       mem_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'(DEPTH));
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'(DEPTH)))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && cnt_r == 2'd0))
    else $error("pop from an empty queue");

endmodule

// ===== rtl/core/dcwd_back.sv =====
// Back end: applies commands to the decoder state and registers the result.
module dcwd_back
  import dcwd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  dcwd_out_if.source out_ch
);

  logic [HALF_W-1:0] lo_r, lo_nxt;
  logic [HALF_W-1:0] hi_r, hi_nxt;
  logic              lo_valid_r, lo_valid_nxt;
  logic              hi_valid_r, hi_valid_nxt;
  logic              in_reset_r, in_reset_nxt;
  logic [1:0]        fsel_r, fsel_nxt;
  logic [1:0]        psel_r, psel_nxt;
  logic [2:0]        wave_r, wave_nxt;
  result_t           out_r, res;
  logic              out_valid_r;

  // Take a command when the output register is free or being drained.
  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // Execute one command against the current state.
  always_comb begin
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    lo_valid_nxt = lo_valid_r;
    hi_valid_nxt = hi_valid_r;
    in_reset_nxt = in_reset_r;
    fsel_nxt     = fsel_r;
    psel_nxt     = psel_r;
    wave_nxt     = wave_r;
    res          = '0;
    res.channel  = q_cmd.chan;
    case (q_cmd.op)
      OP_EMPTY: begin
        res.event_kind = EV_EMPTY;
        res.channel    = 1'b0;
      end
      OP_LONG: begin
        res.event_kind = EV_LONG;
        res.channel    = 1'b0;
      end
      OP_SHORT_PAIR: begin
        res.event_kind = EV_SHORT_PAIR;
      end
      OP_PHASE: begin
        res.event_kind  = EV_PHASE;
        res.phase_value = q_cmd.data[PHASE_W-1:0];
      end
      OP_PAIR: begin
        // Both halves arrive together, so the word is complete at once.
        res.event_kind     = EV_FREQ;
        res.frequency_word = {q_cmd.data2, q_cmd.data};
        lo_valid_nxt       = 1'b0;
        hi_valid_nxt       = 1'b0;
      end
      OP_UPPER: begin
        if (lo_valid_r) begin
          res.event_kind     = EV_FREQ;
          res.frequency_word = {q_cmd.data, lo_r};
          lo_valid_nxt       = 1'b0;
          hi_valid_nxt       = 1'b0;
        end else begin
          res.event_kind = EV_HALF;
          hi_nxt         = q_cmd.data;
          hi_valid_nxt   = 1'b1;
        end
      end
      OP_LOWER: begin
        if (hi_valid_r) begin
          res.event_kind     = EV_FREQ;
          res.frequency_word = {hi_r, q_cmd.data};
          lo_valid_nxt       = 1'b0;
          hi_valid_nxt       = 1'b0;
        end else begin
          res.event_kind = EV_HALF;
          lo_nxt         = q_cmd.data;
          lo_valid_nxt   = 1'b1;
        end
      end
      OP_CTRL: begin
        res.channel = 1'b0;
        if (q_cmd.data[BIT_RESET] && !in_reset_r) begin
          res.event_kind = EV_ENTER_RESET;
          in_reset_nxt   = 1'b1;
        end else begin
          res.event_kind           = EV_CONTROL;
          in_reset_nxt             = q_cmd.data[BIT_RESET];
          fsel_nxt                 = {1'b0, q_cmd.data[BIT_FSEL]};
          psel_nxt                 = {1'b0, q_cmd.data[BIT_PSEL]};
          wave_nxt                 = decode_wave(q_cmd.data, wave_r);
          res.freq_select_changed  = (fsel_nxt != fsel_r);
          res.phase_select_changed = (psel_nxt != psel_r);
          res.waveform_changed     = (wave_nxt != wave_r);
        end
      end
      default: begin
        res.event_kind = EV_EMPTY;
      end
    endcase
    res.reset_active     = in_reset_nxt;
    res.freq_select_now  = fsel_nxt;
    res.phase_select_now = psel_nxt;
    res.waveform_now     = wave_nxt;
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_valid_r  <= 1'b0;
      hi_valid_r  <= 1'b0;
      in_reset_r  <= 1'b0;
      fsel_r      <= SEL_NEVER;
      psel_r      <= SEL_NEVER;
      wave_r      <= WAVE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        lo_valid_r <= lo_valid_nxt;
        hi_valid_r <= hi_valid_nxt;
        in_reset_r <= in_reset_nxt;
        fsel_r     <= fsel_nxt;
        psel_r     <= psel_nxt;
        wave_r     <= wave_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Half words and the result payload need no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      out_r <= res;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.event_kind           = out_r.event_kind;
  assign out_ch.channel              = out_r.channel;
  assign out_ch.phase_value          = out_r.phase_value;
  assign out_ch.frequency_word       = out_r.frequency_word;
  assign out_ch.reset_active         = out_r.reset_active;
  assign out_ch.freq_select_now      = out_r.freq_select_now;
  assign out_ch.phase_select_now     = out_r.phase_select_now;
  assign out_ch.waveform_now         = out_r.waveform_now;
  assign out_ch.freq_select_changed  = out_r.freq_select_changed;
  assign out_ch.phase_select_changed = out_r.phase_select_changed;
  assign out_ch.waveform_changed     = out_r.waveform_changed;

  a_halves_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(lo_valid_r && hi_valid_r))
    else $error("both frequency halves held at once");

  a_freq_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && res.event_kind == EV_FREQ |=> !lo_valid_r && !hi_valid_r)
    else $error("completed frequency word left a half pending");

  a_enter_reset: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && res.event_kind == EV_ENTER_RESET |=>
      in_reset_r && $stable(wave_r) && $stable(fsel_r) && $stable(psel_r))
    else $error("entering reset changed more than the reset state");

  a_flags_control_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind != EV_CONTROL |->
      !(out_r.freq_select_changed || out_r.phase_select_changed
        || out_r.waveform_changed))
    else $error("change flag set outside a control event");

endmodule
